@@ rtl/scd_pkg.sv @@
// Shared types and constants of the speed change decider.
// Used by scd_div and speed_change_decider; depends on nothing else.
`default_nettype none

package scd_pkg;

	// Result codes of the change word.
	typedef enum logic [1:0] {
		CH_INC  = 2'd0,
		CH_DEC  = 2'd1,
		CH_SAME = 2'd2,
		CH_ERR  = 2'd3
	} change_t;

	// Configuration register indexes.
	localparam logic REG_ACCEL = 1'b0;
	localparam logic REG_TSTEP = 1'b1;

	// Register widths and reset values.
	localparam int CFG_W = 31;
	localparam logic [CFG_W-1:0] ACCEL_RESET = 31'd65536;
	localparam logic [CFG_W-1:0] TSTEP_RESET = 31'd656;

	// Divider geometry: quotient bits retired per stage and stage count.
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = 32;
	localparam int DIVIDEND_W = DIV_BITS * DIV_STAGES;

	// Values that ride alongside the division.
	typedef struct packed {
		logic        hit;   // decision already settled before the division
		change_t     code;  // settled decision
		logic        ahead; // target lies ahead of the position
		logic [32:0] ds;    // distance to target
		logic [62:0] md;    // |v| * time step
		logic [61:0] ad;    // accel * time step
	} side_t;

endpackage

`default_nettype wire

@@ rtl/scd_div.sv @@
// Pipelined restoring divider: 64-bit dividend by 31-bit divisor, two
// quotient bits per stage, with a sideband word carried in step.
// Depends on scd_pkg.
`default_nettype none

module scd_div
	import scd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_valid,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [CFG_W-1:0]      divisor,
	input  wire side_t                 in_side,
	output logic                       out_valid,
	output logic [DIVIDEND_W-1:0]      quotient,
	output side_t                      out_side
);

	// Partial remainder plus a word that shifts dividend bits out of the top
	// while quotient bits enter at the bottom.
	typedef struct packed {
		logic [CFG_W-1:0]      rem;
		logic [DIVIDEND_W-1:0] work;
	} div_st_t;

	// Retires DIV_BITS quotient bits; the remainder stays below the divisor.
	function automatic div_st_t div_step(input div_st_t cur, input logic [CFG_W-1:0] dvs);
		div_st_t        nxt;
		logic [CFG_W:0] trial;
		nxt = cur;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {nxt.rem, nxt.work[DIVIDEND_W-1]};
			nxt.work = {nxt.work[DIVIDEND_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs}) begin
				nxt.rem = CFG_W'(trial - {1'b0, dvs});
				nxt.work[0] = 1'b1;
			end else begin
				nxt.rem = trial[CFG_W-1:0];
			end
		end
		return nxt;
	endfunction

	logic [DIV_STAGES-1:0] valid_q;
	div_st_t               st_q   [DIV_STAGES];
	side_t                 side_q [DIV_STAGES];
	div_st_t               st_in  [DIV_STAGES];
	side_t                 side_in[DIV_STAGES];
	logic [DIV_STAGES-1:0] valid_in;

	// Stage inputs: the first stage takes the new word, the rest chain on.
	assign st_in[0]    = '{rem: '0, work: dividend};
	assign side_in[0]  = in_side;
	assign valid_in[0] = in_valid;

	for (genvar g = 1; g < DIV_STAGES; g++) begin : g_chain
		assign st_in[g]    = st_q[g-1];
		assign side_in[g]  = side_q[g-1];
		assign valid_in[g] = valid_q[g-1];
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	// Division step and sideband of every stage.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				st_q[g]   <= div_step(st_in[g], divisor);
				side_q[g] <= side_in[g];
			end
		end
	end

	assign out_valid = valid_q[DIV_STAGES-1];
	assign quotient  = st_q[DIV_STAGES-1].work;
	assign out_side  = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/speed_change_decider.sv @@
// Top level of the speed change decider: configuration registers, input and
// decision stages around the pipelined divider. Depends on scd_pkg, scd_div.
`default_nettype none

// Decides for one axis whether its speed should increase, decrease or stay,
// by a bang-bang profile: near target, then wrong direction, then remaining
// distance against the stopping distance (v^2/a + |v|*dt)/2 with v^2/a
// truncated. A zero acceleration or time step gives the error code. The block
// takes one word per cycle while the output is not stalled, through four
// input and multiply stages, the 32 stages of the divider for v^2/a (two
// quotient bits each), and two compare stages ending in the output register.
// A stall on the output holds the whole pipeline. Configuration writes are
// to be made only while no word is in flight.
module speed_change_decider
	import scd_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic signed [31:0] velocity,
	input  wire logic signed [31:0] position,
	input  wire logic signed [31:0] target,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             change
);

	localparam int NEAR_W = (33 + 2*FRAC_BITS > 93) ? 33 + 2*FRAC_BITS : 93;
	localparam int MAGA_W = (32 + FRAC_BITS > 62) ? 32 + FRAC_BITS : 62;
	localparam int SLOW_W = 65 + FRAC_BITS;

	logic [CFG_W-1:0] accel_q;
	logic [CFG_W-1:0] time_step_q;
	logic             adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q     <= ACCEL_RESET;
			time_step_q <= TSTEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEL: accel_q     <= cfg_data;
				REG_TSTEP: time_step_q <= cfg_data;
			endcase
		end
	end

	// The pipeline moves unless a finished word waits on the output.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: magnitude, distance and direction flags.
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [31:0] mag_s1;
	logic [32:0] ds_s1;
	logic        ahead_s1, behind_s1, vpos_s1, vneg_s1, err_s1;
	logic [32:0] diff_c;

	assign diff_c = {target[31], target} - {position[31], position};

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1    <= velocity[31] ? 32'(-velocity) : 32'(velocity);
			ds_s1     <= diff_c[32] ? 33'(-diff_c) : diff_c;
			ahead_s1  <= position < target;
			behind_s1 <= position > target;
			vpos_s1   <= !velocity[31] && (velocity != '0);
			vneg_s1   <= velocity[31];
			err_s1    <= (accel_q == '0) || (time_step_q == '0);
		end
	end

	// Stage 2: a*dt, v^2 and |v|*dt.
	logic [61:0] ad_s2;
	logic [63:0] sq_s2;
	logic [62:0] md_s2;
	logic [31:0] mag_s2;
	logic [32:0] ds_s2;
	logic        ahead_s2, behind_s2, vpos_s2, vneg_s2, err_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ad_s2     <= accel_q * time_step_q;
			sq_s2     <= mag_s1 * mag_s1;
			md_s2     <= mag_s1 * time_step_q;
			mag_s2    <= mag_s1;
			ds_s2     <= ds_s1;
			ahead_s2  <= ahead_s1;
			behind_s2 <= behind_s1;
			vpos_s2   <= vpos_s1;
			vneg_s2   <= vneg_s1;
			err_s2    <= err_s1;
		end
	end

	// Stage 3: partial products of a*dt*dt and the slow-speed compare.
	logic [61:0] pp_lo_s3, pp_hi_s3;
	logic [61:0] ad_s3;
	logic [63:0] sq_s3;
	logic [62:0] md_s3;
	logic [32:0] ds_s3;
	logic        slow_s3, ahead_s3, behind_s3, vpos_s3, vneg_s3, err_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_lo_s3  <= ad_s2[30:0] * time_step_q;
			pp_hi_s3  <= ad_s2[61:31] * time_step_q;
			slow_s3   <= (MAGA_W'(mag_s2) << FRAC_BITS) < MAGA_W'(ad_s2);
			ad_s3     <= ad_s2;
			sq_s3     <= sq_s2;
			md_s3     <= md_s2;
			ds_s3     <= ds_s2;
			ahead_s3  <= ahead_s2;
			behind_s3 <= behind_s2;
			vpos_s3   <= vpos_s2;
			vneg_s3   <= vneg_s2;
			err_s3    <= err_s2;
		end
	end

	// Stage 4: error, near-target and wrong-direction rules settle the early cases.
	logic [92:0] add_c;
	logic        near_c;
	side_t       side_c;
	side_t       side_s4;
	logic [63:0] sq_s4;

	assign add_c  = (93'(pp_hi_s3) << 31) + 93'(pp_lo_s3);
	assign near_c = (NEAR_W'(ds_s3) << (2*FRAC_BITS)) < NEAR_W'(add_c);

	always_comb begin
		side_c.ds    = ds_s3;
		side_c.md    = md_s3;
		side_c.ad    = ad_s3;
		side_c.ahead = ahead_s3;
		side_c.hit   = 1'b1;
		side_c.code  = CH_ERR;
		if (err_s3) begin
			side_c.code = CH_ERR;
		end else if (near_c) begin
			if (slow_s3) begin
				side_c.code = CH_SAME;
			end else begin
				side_c.code = vpos_s3 ? CH_DEC : CH_INC;
			end
		end else if (ahead_s3 && !vpos_s3) begin
			side_c.code = CH_INC;
		end else if (behind_s3 && !vneg_s3) begin
			side_c.code = CH_DEC;
		end else begin
			side_c.hit = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_c;
			sq_s4   <= sq_s3;
		end
	end

	// Division v^2 / a.
	logic                  div_valid;
	logic [DIVIDEND_W-1:0] div_q;
	side_t                 div_side;

	scd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_s4),
		.dividend  (sq_s4),
		.divisor   (accel_q),
		.in_side   (side_s4),
		.out_valid (div_valid),
		.quotient  (div_q),
		.out_side  (div_side)
	);

	// Stage 5: twice the stopping distance and twice the remaining distance.
	logic [SLOW_W-1:0] xd2_s5, two_s5;
	side_t             side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			xd2_s5  <= (SLOW_W'(div_q) << FRAC_BITS) + SLOW_W'(div_side.md);
			two_s5  <= SLOW_W'(div_side.ds) << (FRAC_BITS + 1);
			side_s5 <= div_side;
		end
	end

	// Stage 6: final decision into the output register.
	logic              lt_c, close_c;
	logic [SLOW_W-1:0] gap_c;
	change_t           code_c;
	change_t           change_s6;

	assign lt_c    = two_s5 < xd2_s5;
	assign gap_c   = two_s5 - xd2_s5;
	assign close_c = gap_c < (SLOW_W'(side_s5.ad) << 1);

	always_comb begin
		if (side_s5.hit) begin
			code_c = side_s5.code;
		end else if (lt_c) begin
			code_c = side_s5.ahead ? CH_DEC : CH_INC;
		end else if (close_c) begin
			code_c = CH_SAME;
		end else begin
			code_c = side_s5.ahead ? CH_INC : CH_DEC;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			change_s6 <= code_c;
		end
	end

	// Valid bits of the stages outside the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= div_valid;
			valid_s6 <= valid_s5;
		end
	end

	assign out_valid = valid_s6;
	assign change    = change_s6;

endmodule

`default_nettype wire

@@ tb/speed_change_decider_tb.sv @@
// Self-checking testbench of speed_change_decider: random and directed queries
// checked against a predictor of the bang-bang decision. Depends on scd_pkg.
module speed_change_decider_tb;
	import scd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;

	typedef struct {
		logic signed [31:0] vel;
		logic signed [31:0] pos;
		logic signed [31:0] tgt;
	} query_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_ACCEL;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] velocity = '0;
	logic signed [31:0] position = '0;
	logic signed [31:0] target = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] change;

	// Copy of the register contents, updated whenever a register is written.
	logic [CFG_W-1:0] accel_cfg = ACCEL_RESET;
	logic [CFG_W-1:0] tstep_cfg = TSTEP_RESET;

	query_t queries_q[$];
	change_t decisions_q[$];
	int src_idle = 0;
	int sink_idle = 0;
	int mismatches = 0;
	logic quiet = 1'b0;

	speed_change_decider #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.velocity(velocity),
		.position(position),
		.target(target),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.change(change)
	);

	always #5 clk = ~clk;

	// Twice the stopping distance, v^2/a truncated plus |v|*dt, at scale 2^-2F.
	function automatic logic [127:0] double_stop_dist(logic [31:0] mag);
		logic [127:0] m;
		logic [127:0] sq;
		m = 128'(mag);
		sq = (m * m) / 128'(accel_cfg);
		return (sq << FRAC) + m * 128'(tstep_cfg);
	endfunction

	// Decision for one query under the current register contents.
	function automatic change_t decide_change(query_t w);
		longint vs, xs, ts, diff;
		logic [127:0] mag, ds, ad, two, xd2;
		logic ahead;
		if (accel_cfg == 0 || tstep_cfg == 0)
			return CH_ERR;
		vs = w.vel;
		xs = w.pos;
		ts = w.tgt;
		mag = (vs < 0) ? 128'(-vs) : 128'(vs);
		diff = ts - xs;
		ds = (diff < 0) ? 128'(-diff) : 128'(diff);
		ad = 128'(accel_cfg) * 128'(tstep_cfg);
		ahead = xs < ts;
		// Near target: stop if slow enough, otherwise brake.
		if ((ds << (2 * FRAC)) < ad * 128'(tstep_cfg)) begin
			if ((mag << FRAC) < ad)
				return CH_SAME;
			return (vs > 0) ? CH_DEC : CH_INC;
		end
		// Moving away from the target or standing still.
		if (ahead && vs <= 0)
			return CH_INC;
		if (xs > ts && vs >= 0)
			return CH_DEC;
		// Remaining distance against the stopping distance.
		xd2 = double_stop_dist(mag[31:0]);
		two = ds << (FRAC + 1);
		if (two < xd2)
			return ahead ? CH_DEC : CH_INC;
		if (two - xd2 < (ad << 1))
			return CH_SAME;
		return ahead ? CH_INC : CH_DEC;
	endfunction

	// Random query: mostly aimed at the near-target zone and at the band around
	// the stopping distance, the rest plain noise.
	function automatic query_t draw_query();
		query_t w;
		logic [127:0] ad, lim;
		logic [31:0] mag, cap, band;
		longint span, off, lo, hi, p;
		longint unsigned r;
		logic ahead, toward;
		int unsigned mode;
		mode = $urandom_range(0, 9);
		ad = 128'(accel_cfg) * 128'(tstep_cfg);
		ahead = 1'($urandom_range(0, 1));
		if (mode < 2 || ad == 0) begin
			w.vel = $urandom;
			w.pos = $urandom;
			w.tgt = $urandom;
			return w;
		end
		if (mode < 4) begin
			lim = (ad * 128'(tstep_cfg)) >> (2 * FRAC);
			cap = (lim > 128'(32'hFFFF_0000)) ? 32'hFFFF_0000 : lim[31:0];
			span = longint'($urandom_range(0, cap + 2));
			lim = ad >> FRAC;
			cap = (lim > 128'(32'h7FFF_0000)) ? 32'h7FFF_0000 : lim[31:0];
			mag = $urandom_range(0, 1) ? $urandom_range(0, cap + 2)
				: ($urandom >> $urandom_range(0, 31));
			toward = 1'($urandom_range(0, 1));
		end else begin
			mag = $urandom >> $urandom_range(0, 31);
			if (mag > 32'h8000_0000)
				mag = 32'h8000_0000;
			lim = double_stop_dist(mag) >> (FRAC + 1);
			span = (lim > 128'(32'hFFFF_FFFF)) ? 64'hFFFF_FFFF : longint'(lim[31:0]);
			lim = ad >> FRAC;
			band = (lim > 128'(32'h0FFF_FFFF)) ? 32'h0FFF_FFFF : lim[31:0];
			if ($urandom_range(0, 3) != 0)
				off = longint'($urandom_range(0, band + 6)) - 3;
			else
				off = (longint'($urandom) - 64'sd2147483648) >>> $urandom_range(0, 31);
			span = span + off;
			if (span < 0)
				span = 0;
			if (span > 64'sd4294967295)
				span = 64'sd4294967295;
			toward = ($urandom_range(0, 7) != 0);
		end
		// Place the pair anywhere the distance fits in the signed range.
		lo = -64'sd2147483648;
		hi = 64'sd2147483647 - span;
		r = {$urandom, $urandom};
		p = lo + longint'(r % longint'(hi - lo + 1));
		if (ahead) begin
			w.pos = 32'(p);
			w.tgt = 32'(p + span);
		end else begin
			w.pos = 32'(p + span);
			w.tgt = 32'(p);
		end
		if (ahead == toward)
			w.vel = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
		else
			w.vel = 32'(-longint'(mag));
		return w;
	endfunction

	task automatic add_query(input logic signed [31:0] v, input logic signed [31:0] x,
			input logic signed [31:0] t);
		query_t w;
		w.vel = v;
		w.pos = x;
		w.tgt = t;
		queries_q.push_back(w);
	endtask

	task automatic set_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_ACCEL)
			accel_cfg = val;
		else
			tstep_cfg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every query is sent and every decision has come back.
	task automatic settle();
		do
			@(negedge clk);
		while (queries_q.size() != 0 || in_valid || decisions_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Query driver: predicts each word as it is taken, then offers the next.
	always @(posedge clk or negedge arst_n) begin
		query_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_idle = 0;
		end else begin
			if (in_valid && !in_stall) begin
				w.vel = velocity;
				w.pos = position;
				w.tgt = target;
				decisions_q.push_back(decide_change(w));
			end
			if (!in_valid || !in_stall) begin
				if (src_idle > 0) begin
					src_idle--;
					in_valid <= 1'b0;
				end else if (queries_q.size() != 0) begin
					w = queries_q.pop_front();
					velocity <= w.vel;
					position <= w.pos;
					target <= w.tgt;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 11) == 0)
						src_idle = $urandom_range(1, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Decision monitor with random stall bursts.
	always @(posedge clk or negedge arst_n) begin
		change_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_idle = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (decisions_q.size() == 0) begin
					$error("change: expected none, got %0d", change);
					mismatches++;
				end else begin
					want = decisions_q.pop_front();
					if (change !== want) begin
						$error("change: expected %0d, got %0d", want, change);
						mismatches++;
					end
				end
			end
			if (sink_idle > 0) begin
				sink_idle--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				sink_idle = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus: directed queries at reset settings, then random phases.
	initial begin
		int unsigned count;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Standing still, and extreme speeds, exactly on target.
		add_query(32'sd0, 32'sd0, 32'sd0);
		add_query(32'sh7FFF_FFFF, 32'sd0, 32'sd0);
		add_query(32'sh8000_0000, 32'sd0, 32'sd0);
		// Wrong direction, including the full position range.
		add_query(32'sd0, 32'sd0, 32'sh7FFF_FFFF);
		add_query(32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		add_query(-32'sd65536, 32'sh8000_0000, 32'sh7FFF_FFFF);
		add_query(32'sd100, 32'sd1000, 32'sd0);
		// Around the stopping distance at speed 1.0, both directions.
		add_query(32'sd65536, 32'sd0, 32'sd32768);
		add_query(32'sd65536, 32'sd0, 32'sd33095);
		add_query(32'sd65536, 32'sd0, 32'sd33096);
		add_query(32'sd65536, 32'sd0, 32'sd33751);
		add_query(32'sd65536, 32'sd0, 32'sd33752);
		add_query(-32'sd65536, 32'sd0, -32'sd33096);
		add_query(-32'sd65536, 32'sd0, -32'sd40000);
		add_query(-32'sd65536, 32'sd0, -32'sd20000);
		// Edges of the near-target zone and of the speed below a*dt.
		add_query(32'sd655, 32'sd0, 32'sd6);
		add_query(32'sd656, 32'sd0, 32'sd6);
		add_query(-32'sd656, 32'sd0, -32'sd6);
		add_query(32'sd655, 32'sd0, 32'sd7);
		// Extreme fields together.
		add_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		add_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		add_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		add_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		settle();

		// Each phase changes the registers while idle, then runs random words.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					set_reg(REG_ACCEL, '0);
					count = 40;
				end
				1: begin
					set_reg(REG_ACCEL, ACCEL_RESET);
					set_reg(REG_TSTEP, '0);
					count = 40;
				end
				2: begin
					set_reg(REG_ACCEL, 31'h7FFF_FFFF);
					set_reg(REG_TSTEP, 31'h7FFF_FFFF);
					count = 50;
				end
				3: begin
					set_reg(REG_ACCEL, 31'd1);
					set_reg(REG_TSTEP, 31'd1);
					count = 90;
				end
				4: begin
					set_reg(REG_ACCEL, 31'($urandom_range(1 << 12, 1 << 22)));
					set_reg(REG_TSTEP, 31'($urandom_range(1, 1 << 14)));
					count = 100;
				end
				5: begin
					set_reg(REG_ACCEL, 31'h7FFF_FFFF);
					set_reg(REG_TSTEP, 31'($urandom_range(1, 1 << 20)));
					count = 100;
				end
				default: begin
					set_reg(REG_ACCEL, ACCEL_RESET);
					set_reg(REG_TSTEP, TSTEP_RESET);
					quiet = 1'b1;
					count = 130;
				end
			endcase
			repeat (count) queries_q.push_back(draw_query());
			settle();
		end

		// Let any stray word surface before the verdict.
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/scd_pkg.sv
rtl/scd_div.sv
rtl/speed_change_decider.sv
tb/speed_change_decider_tb.sv
